// File: sv/calendar_to_epoch_seconds_defines.svh
// assertion macros shared by the calendar to epoch seconds design
`ifndef CALENDAR_TO_EPOCH_SECONDS_DEFINES_SVH
`define CALENDAR_TO_EPOCH_SECONDS_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define C2E_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define C2E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define C2E_ASSERT_IMP(lbl, ante, cons, msg)
`define C2E_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/c2e_pkg.sv
// shared types, constants and tables of the calendar to epoch seconds pipeline
package c2e_pkg;

    localparam int unsigned YEAR_W  = 15;   // adjusted year, 1997 to 16404
    localparam int unsigned CENT_W  = 8;    // year / 100, at most 164
    localparam int unsigned DAYS_W  = 23;   // day count since the epoch
    localparam int unsigned TOD_W   = 20;   // seconds within the day count
    localparam int unsigned EPOCH_W = 48;

    localparam logic [13:0] YEAR_PIVOT = 14'd2000;
    localparam logic [14:0] YEAR_SHIFT = 15'd1998;
    // floor(m / 12) = (m * 171) >> 11 for m below 256
    localparam logic [7:0]  RECIP_12   = 8'd171;
    localparam int unsigned SHIFT_12   = 11;
    // floor(y / 100) = (y * 5243) >> 19 for y below 43699
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int unsigned SHIFT_100  = 19;
    // 365 * 1970 + 477 leap days before the epoch + one for the 1 based day
    localparam logic [23:0] DAY_BIAS   = 24'd719528;
    localparam logic [16:0] SECS_DAY   = 17'd86400;

    typedef struct packed {
        logic [YEAR_W-1:0] yr_base;
        logic [4:0]        yq;
        logic              ydec;
        logic [3:0]        midx;
        logic [7:0]        day;
        logic [TOD_W-1:0]  tod;
    } t_split;

    typedef struct packed {
        logic [YEAR_W-1:0] yr;
        logic [CENT_W-1:0] qy;
        logic [CENT_W-1:0] qp;
        logic [3:0]        midx;
        logic [7:0]        day;
        logic [TOD_W-1:0]  tod;
    } t_year;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } t_days;

    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        unique case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: sv/c2e_date_split.sv
// stage 1: year quirk, month roll into year, time of day in seconds
module c2e_date_split (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [13:0]         i_cal_year,
    input  logic [7:0]          i_cal_month,
    input  logic [7:0]          i_cal_day,
    input  logic [7:0]          i_cal_hour,
    input  logic [7:0]          i_cal_minute,
    input  logic [7:0]          i_cal_second,
    output logic                o_valid,
    input  logic                i_ready,
    output c2e_pkg::t_split     o_data
);

    logic            r_valid;
    c2e_pkg::t_split r_data;
    c2e_pkg::t_split n_data;
    logic [7:0]      mo;
    logic [15:0]     prod12;
    logic [4:0]      q12;
    logic [7:0]      rem12;

    assign mo     = i_cal_month - 8'd1;
    assign prod12 = 16'(mo) * 16'(c2e_pkg::RECIP_12);
    assign q12    = prod12[c2e_pkg::SHIFT_12 +: 5];
    assign rem12  = mo - 8'({q12, 3'b000}) - 8'({q12, 2'b00});

    always_comb begin
        n_data.yr_base = (i_cal_year > c2e_pkg::YEAR_PIVOT) ? 15'(i_cal_year)
                       : 15'(i_cal_year) + c2e_pkg::YEAR_SHIFT;
        // month zero is december of the year before
        if (i_cal_month == 8'd0) begin
            n_data.yq   = 5'd0;
            n_data.ydec = 1'b1;
            n_data.midx = 4'd11;
        end else begin
            n_data.yq   = q12;
            n_data.ydec = 1'b0;
            n_data.midx = rem12[3:0];
        end
        n_data.day = i_cal_day;
        n_data.tod = 20'(i_cal_hour) * 20'd3600 + 20'(i_cal_minute) * 20'd60
                   + 20'(i_cal_second);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/c2e_year_div.sv
// stage 2: final year and century quotients of the year and the year before
module c2e_year_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  c2e_pkg::t_split     i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output c2e_pkg::t_year      o_data
);

    logic                       r_valid;
    c2e_pkg::t_year             r_data;
    c2e_pkg::t_year             n_data;
    logic [c2e_pkg::YEAR_W-1:0] yr;
    logic [c2e_pkg::YEAR_W-1:0] yp;
    logic [27:0]                prod_y;
    logic [27:0]                prod_p;

    assign yr     = i_data.yr_base + 15'(i_data.yq) - 15'(i_data.ydec);
    assign yp     = yr - 15'd1;
    assign prod_y = 28'(yr) * 28'(c2e_pkg::RECIP_100);
    assign prod_p = 28'(yp) * 28'(c2e_pkg::RECIP_100);

    always_comb begin
        n_data.yr   = yr;
        n_data.qy   = prod_y[c2e_pkg::SHIFT_100 +: c2e_pkg::CENT_W];
        n_data.qp   = prod_p[c2e_pkg::SHIFT_100 +: c2e_pkg::CENT_W];
        n_data.midx = i_data.midx;
        n_data.day  = i_data.day;
        n_data.tod  = i_data.tod;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/c2e_day_count.sv
// stage 3: days since the epoch from year, month and day
module c2e_day_count (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  c2e_pkg::t_year      i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output c2e_pkg::t_days      o_data
);

    logic                       r_valid;
    c2e_pkg::t_days             r_data;
    c2e_pkg::t_days             n_data;
    logic [c2e_pkg::YEAR_W-1:0] yp;
    logic                       is_cent;
    logic                       is_leap;
    logic                       add_leap;
    logic [23:0]                sum;

    assign yp       = i_data.yr - 15'd1;
    assign is_cent  = (i_data.yr == 15'(i_data.qy) * 15'd100);
    // every 4th year, except centuries, except every 400th
    assign is_leap  = ((i_data.yr[1:0] == 2'd0) && !is_cent)
                   || (is_cent && (i_data.qy[1:0] == 2'd0));
    assign add_leap = is_leap && (i_data.midx >= 4'd2);

    // leap days before the year: p/4 - p/100 + p/400
    assign sum = 24'(i_data.yr) * 24'd365 + 24'(yp[14:2]) - 24'(i_data.qp)
               + 24'(i_data.qp[7:2]) + 24'(c2e_pkg::days_before_month(i_data.midx))
               + 24'(add_leap) + 24'(i_data.day) - c2e_pkg::DAY_BIAS;

    always_comb begin
        n_data.days = sum[c2e_pkg::DAYS_W-1:0];
        n_data.tod  = i_data.tod;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/c2e_sec_scale.sv
// stage 4: days to seconds plus time of day, output register
module c2e_sec_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  c2e_pkg::t_days                i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [c2e_pkg::EPOCH_W-1:0]   o_epoch_seconds
);

    logic                          r_valid;
    logic [c2e_pkg::EPOCH_W-1:0]   r_epoch;
    logic [c2e_pkg::EPOCH_W-1:0]   n_epoch;

    assign n_epoch = 48'(i_data.days) * 48'(c2e_pkg::SECS_DAY) + 48'(i_data.tod);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_epoch <= n_epoch;
        end
    end

    assign o_valid         = r_valid;
    assign o_epoch_seconds = r_epoch;

endmodule

// File: sv/calendar_to_epoch_seconds.sv
// top level: calendar time to seconds since 1970-01-01, four stage pipeline
//
// input channel: i_valid / o_ready with year, month, day, hour, minute and
//   second; a transfer happens on a rising edge with both high
// output channel: o_valid / i_ready with o_epoch_seconds, one result for
//   each input transfer, in order
// years above 2000 are used as given, years of 2000 or less get 1998 added;
//   months outside 1 to 12 roll into the year, day/hour/minute/second are
//   added unchecked
// throughput: one transfer per cycle while i_ready is high, set by the
//   pipeline registers; each stage holds one item
// stages: month split and time of day, century quotients by reciprocal
//   multiply, day count, days times 86400 into the output register
// reset: synchronous, active low; clears every stage valid, no item in flight
// receiver stall: the output register holds, stages fill up behind it and
//   o_ready drops once all four stages hold items; nothing is dropped
`include "calendar_to_epoch_seconds_defines.svh"

module calendar_to_epoch_seconds (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [13:0]                  i_cal_year,
    input  logic [7:0]                   i_cal_month,
    input  logic [7:0]                   i_cal_day,
    input  logic [7:0]                   i_cal_hour,
    input  logic [7:0]                   i_cal_minute,
    input  logic [7:0]                   i_cal_second,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [c2e_pkg::EPOCH_W-1:0]  o_epoch_seconds
);

    // stage handshakes, ready runs back from the output register
    logic            s1_valid;
    logic            s1_ready;
    logic            s2_valid;
    logic            s2_ready;
    logic            s3_valid;
    logic            s3_ready;
    c2e_pkg::t_split s1_data;
    c2e_pkg::t_year  s2_data;
    c2e_pkg::t_days  s3_data;

    // year quirk, month split, seconds within the day
    c2e_date_split u_split (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cal_year   (i_cal_year),
        .i_cal_month  (i_cal_month),
        .i_cal_day    (i_cal_day),
        .i_cal_hour   (i_cal_hour),
        .i_cal_minute (i_cal_minute),
        .i_cal_second (i_cal_second),
        .o_valid      (s1_valid),
        .i_ready      (s1_ready),
        .o_data       (s1_data)
    );

    // final year and divide by 100 through reciprocal multiplies
    c2e_year_div u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    // days since the epoch with gregorian leap rules
    c2e_day_count u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    // scale to seconds, this stage is the output register
    c2e_sec_scale u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s3_valid),
        .o_ready         (s3_ready),
        .i_data          (s3_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_epoch_seconds (o_epoch_seconds)
    );

    // a free receiver lets the whole pipeline move
    `C2E_ASSERT_IMP(a_ready_chain, i_ready, o_ready && s1_ready && s2_ready && s3_ready,
        "pipeline stalled although the receiver is ready")
    // month split always lands on a real month
    `C2E_ASSERT_IMP(a_month_idx, s1_valid, s1_data.midx <= 4'd11,
        "month index out of range after split")
    // adjusted year stays in its known span
    `C2E_ASSERT_IMP(a_year_span, s2_valid, s2_data.yr >= 15'd1997 && s2_data.yr <= 15'd16404,
        "adjusted year out of range")
    // an output transfer with more work behind it keeps o_valid up
    `C2E_ASSERT_NEXT(a_drain, o_valid && i_ready && s3_valid, o_valid,
        "pipeline lost an item at the output")

endmodule
